FILE: rtl/core/urdiv_pkg.sv
package urdiv_pkg;

	localparam int unsigned DEF_WIDTH = 32;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_DIV_ZERO = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic out_load;
	} ctl_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_BUSY = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage

FILE: rtl/core/urdiv_cell.sv
module urdiv_cell (
	input  logic            clk,
	input  urdiv_pkg::ctl_t ctl,
	input  logic            dividend_bit,
	input  logic            divisor_bit,
	input  logic            r_in,
	input  logic            q_in,
	input  logic            b_in,
	input  logic            ge,
	output logic            r_q,
	output logic            q_q,
	output logic            b_out
);
	import urdiv_pkg::*;

	logic d_q;
	logic diff;

	// one bit of the trial subtract, borrow ripples to the next cell
	assign diff  = r_in ^ d_q ^ b_in;
	assign b_out = (~r_in & d_q) | (~(r_in ^ d_q) & b_in);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q <= 1'b0;
			q_q <= dividend_bit;
			d_q <= divisor_bit;
		end else if (ctl.step) begin
			r_q <= ge ? diff : r_in;
			q_q <= q_in;
		end
	end

endmodule

FILE: rtl/core/urdiv_ctrl.sv
module urdiv_ctrl #(
	parameter int unsigned WIDTH = urdiv_pkg::DEF_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output urdiv_pkg::ctl_t ctl
);
	import urdiv_pkg::*;

	localparam int unsigned CNT_W = $clog2(WIDTH);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free     = !out_valid_q || rsp_ready;
	assign req_ready    = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
	assign ctl.load     = req_valid && req_ready;
	assign ctl.step     = (state_q == S_BUSY);
	assign ctl.out_load = (state_q == S_DONE) && out_free;
	assign rsp_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cnt_q <= CNT_W'(WIDTH - 1);
			end else if (ctl.step) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (ctl.load) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= ctl.load ? S_BUSY : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/unsigned_restoring_divider.sv
// channel | signals                                   | transaction
// req     | req_valid, req_ready, dividend, divisor  | one division
// rsp     | rsp_valid, rsp_ready, quotient, remainder, status | one result
//
// each division is a load of the operands into the bit cells, followed by
// WIDTH shift-and-subtract steps across the cell row, one quotient bit each.
// the result sits in an output register; a new request loads in the same cycle
// the previous result moves there, so a request is taken only once the previous
// division is done. a stalled response holds the finished division in the cells.
// reset clears the sequencer and the response valid only.
module unsigned_restoring_divider #(
	parameter int unsigned WIDTH = urdiv_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output logic             status
);
	import urdiv_pkg::*;

	ctl_t             ctl;
	logic [WIDTH-1:0] r_bits;
	logic [WIDTH-1:0] q_bits;
	logic [WIDTH:0]   borrow;
	logic             ge;
	logic             err_q;
	logic [WIDTH-1:0] quotient_q;
	logic [WIDTH-1:0] remainder_q;
	logic             status_q;

	urdiv_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	assign borrow[0] = 1'b0;
	// subtract when the shifted-out bit is set or no borrow leaves the row
	assign ge = r_bits[WIDTH-1] | ~borrow[WIDTH];

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		urdiv_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.dividend_bit (dividend[i]),
			.divisor_bit  (divisor[i]),
			.r_in         ((i == 0) ? q_bits[WIDTH-1] : r_bits[(i == 0) ? 0 : i-1]),
			.q_in         ((i == 0) ? ge : q_bits[(i == 0) ? 0 : i-1]),
			.b_in         (borrow[i]),
			.ge           (ge),
			.r_q          (r_bits[i]),
			.q_q          (q_bits[i]),
			.b_out        (borrow[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			err_q <= (divisor == '0);
		end
		if (ctl.out_load) begin
			quotient_q  <= err_q ? '0 : q_bits;
			remainder_q <= err_q ? '0 : r_bits;
			status_q    <= err_q ? ST_DIV_ZERO : ST_OK;
		end
	end

	assign quotient  = quotient_q;
	assign remainder = remainder_q;
	assign status    = status_q;

endmodule

FILE: rtl/core/urdiv_checker.sv
module urdiv_checker #(
	parameter int unsigned WIDTH = urdiv_pkg::DEF_WIDTH
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic [WIDTH-1:0] dividend,
	input logic [WIDTH-1:0] divisor,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [WIDTH-1:0] quotient,
	input logic [WIDTH-1:0] remainder,
	input logic             status
);
	import urdiv_pkg::*;

	// request held until taken
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(dividend) && $stable(divisor))
		else $error("request dropped or changed while stalled");

	// response held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient) && $stable(remainder)
			&& $stable(status))
		else $error("response dropped or changed while stalled");

	// one division at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a division is running");

	// no new request while the shift-and-subtract steps of a division run
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready [*WIDTH])
		else $error("request taken before the division finished");

	// divide by zero forces zero results
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_DIV_ZERO) |-> (quotient == '0) && (remainder == '0))
		else $error("nonzero result on divide by zero");

endmodule

bind unsigned_restoring_divider urdiv_checker #(.WIDTH(WIDTH)) u_urdiv_checker (.*);

FILE: tb/tb_top.sv
module tb_top;

	localparam int unsigned W = urdiv_pkg::DEF_WIDTH;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] TOP_BIT = ALL_ONES ^ (ALL_ONES >> 1);

	typedef struct packed {
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
		logic         status;
	} division_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         req_valid;
	logic         req_ready;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;
	logic         rsp_valid;
	logic         rsp_ready = 1'b0;
	logic [W-1:0] quotient;
	logic [W-1:0] remainder;
	logic         status;

	division_t   pending_divisions[$];
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	unsigned_restoring_divider #(
		.WIDTH(W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.dividend (dividend),
		.divisor  (divisor),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.quotient (quotient),
		.remainder(remainder),
		.status   (status)
	);

	always #1 clk = ~clk;

	// long division, one quotient bit per step from the top
	function automatic division_t divide_operands(logic [W-1:0] num, logic [W-1:0] den);
		division_t  res;
		logic [W:0] partial;
		res.dividend  = num;
		res.divisor   = den;
		res.quotient  = '0;
		res.remainder = '0;
		res.status    = urdiv_pkg::ST_OK;
		if (den == '0) begin
			res.status = urdiv_pkg::ST_DIV_ZERO;
			return res;
		end
		partial = '0;
		for (int i = W - 1; i >= 0; i--) begin
			partial = {partial[W-1:0], num[i]};
			if (partial >= {1'b0, den}) begin
				partial = partial - {1'b0, den};
				res.quotient[i] = 1'b1;
			end
		end
		res.remainder = partial[W-1:0];
		return res;
	endfunction

	// random operand whose leading one sits at bit n-1, or zero when n is 0
	function automatic logic [W-1:0] operand_of_length(int unsigned n);
		logic [W-1:0] v;
		v = W'({$urandom, $urandom});
		if (n == 0)
			return '0;
		v = v & (ALL_ONES >> (W - n));
		v[n-1] = 1'b1;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		error_count++;
	endtask

	// one division transaction; valid stays high afterwards unless the next one idles
	task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		dividend  <= num;
		divisor   <= den;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_divisions.push_back(divide_operands(num, den));
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (pending_divisions.size() != 0)
			@(posedge clk);
		repeat (W + 4) @(posedge clk);
	endtask

	task automatic run_random_divisions(input int unsigned count);
		int unsigned  kind;
		int unsigned  len_a;
		logic [W-1:0] a;
		logic [W-1:0] b;
		for (int unsigned n = 0; n < count; n++) begin
			kind  = $urandom_range(99);
			len_a = $urandom_range(W, 1);
			a     = operand_of_length(len_a);
			if (kind < 60) begin
				b = operand_of_length($urandom_range(len_a, 1));
			end else if (kind < 70) begin
				a = $urandom;
				b = $urandom;
			end else if (kind < 78) begin
				b = operand_of_length($urandom_range(W, 1));
				a = operand_of_length($urandom_range(W, 0));
				if (a > b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end else if (kind < 85) begin
				b = a;
			end else if (kind < 92) begin
				b = '0;
			end else if (kind < 97) begin
				b = $urandom;
				a = '0;
			end else begin
				a = $urandom_range(15);
				b = $urandom_range(15);
			end
			send_division(a, b);
		end
	endtask

	task automatic test_special_cases();
		send_idle_pct = 22;
		recv_idle_pct = 68;
		// zero divisor
		send_division('0, '0);
		send_division(ALL_ONES, '0);
		send_division(12345, '0);
		// zero dividend
		send_division('0, 1);
		send_division('0, ALL_ONES);
		// equal operands
		send_division(1, 1);
		send_division(ALL_ONES, ALL_ONES);
		send_division(TOP_BIT, TOP_BIT);
		// divisor above dividend
		send_division(1, 2);
		send_division(5, ALL_ONES);
		send_division(ALL_ONES - 1, ALL_ONES);
		send_division(TOP_BIT, ALL_ONES);
		// full alignment range
		send_division(ALL_ONES, 1);
		send_division(ALL_ONES, 2);
		send_division(TOP_BIT, 1);
		send_division(ALL_ONES, TOP_BIT);
		send_division(100, 7);
		send_division(ALL_ONES >> 1, 3);
		send_division({(W/2){2'b10}}, {(W/2){2'b01}});
		send_division(64, 8);
		send_division(65, 8);
		send_division(TOP_BIT | 1, TOP_BIT >> 1);
		wait_quiet();
	endtask

	task automatic test_slow_receiver(input int unsigned count);
		send_idle_pct = 22;
		recv_idle_pct = 68;
		run_random_divisions(count);
		wait_quiet();
	endtask

	task automatic test_slow_sender(input int unsigned count);
		send_idle_pct = 68;
		recv_idle_pct = 22;
		run_random_divisions(count);
		wait_quiet();
	endtask

	task automatic test_full_rate(input int unsigned count);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_divisions(count);
		wait_quiet();
	endtask

	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		division_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_divisions.size() == 0) begin
				report_mismatch($sformatf("result with no division pending: q %h r %h st %b",
					quotient, remainder, status));
			end else begin
				want = pending_divisions.pop_front();
				if (quotient !== want.quotient)
					report_mismatch($sformatf("%h / %h: quotient %h, expected %h",
						want.dividend, want.divisor, quotient, want.quotient));
				if (remainder !== want.remainder)
					report_mismatch($sformatf("%h / %h: remainder %h, expected %h",
						want.dividend, want.divisor, remainder, want.remainder));
				if (status !== want.status)
					report_mismatch($sformatf("%h / %h: status %b, expected %b",
						want.dividend, want.divisor, status, want.status));
			end
		end
	end

	// no transaction on either channel for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("unsigned_restoring_divider verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		dividend  <= '0;
		divisor   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_slow_receiver(620);
		test_slow_sender(620);
		test_full_rate(590);
		if (error_count == 0)
			$display("unsigned_restoring_divider verification clean");
		else
			$display("unsigned_restoring_divider verification failed");
		$finish;
	end

endmodule
